/* sv/hpl_pkg.sv */
`timescale 1ns / 1ps

package hpl_pkg;

    // Field widths of the stream words.
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int SEG_W    = 31;
    localparam int TOTAL_W  = 48;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 80;

    // Magnitude of a coordinate difference, and the wrapped longitude difference.
    localparam int MAG_W  = 31;
    localparam int DLON_W = 35;

    // Default datapath settings.
    localparam int STEPS_DEFAULT = 24;
    localparam int FRAC_DEFAULT  = 30;

    // Square root unit widths.
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;

    // Arithmetic constants.
    localparam logic [31:0] DEG7_TO_RAD     = 32'd4024455254;
    localparam logic [63:0] QUARTER_PI_Q62  = 64'd3622009729038561421;
    localparam logic [31:0] INV_GAIN_Q32    = 32'd2608131496;
    localparam logic [30:0] EARTH_DIAM_CM   = 31'd1274200000;
    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;
    localparam logic signed [DLON_W-1:0] LON_TURN = 35'sd3600000000;
    localparam logic signed [DLON_W-1:0] LON_HALF = 35'sd1800000000;
    localparam logic [SEG_W-1:0] SEGMENT_MAX      = 31'd2001508680;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX      = '1;

    // CORDIC operating mode.
    typedef enum logic {
        CMODE_ROT,
        CMODE_VEC
    } cordic_mode_t;

    // Width of the CORDIC x, y and z registers.
    function automatic int cordic_width(input int frac);
        return (frac + 3 > 35) ? frac + 3 : 35;
    endfunction

    // Operand width of the shift-add multiplier.
    function automatic int mul_width(input int frac);
        return (frac + 2 > 32) ? frac + 2 : 32;
    endfunction

    // Long division, used only to build constant tables at elaboration.
    function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q62 from its power series; pi/4 for the first step.
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] sum;
        int          e;
        sum = '0;
        if (i == 0)
            return QUARTER_PI_Q62;
        for (int k = 0; k < 32; k++)
        begin
            e = i * (2 * k + 1);
            if (e <= 62)
            begin
                if (k[0])
                    sum = sum - div_floor(64'd1 << (62 - e), 64'(2 * k + 1));
                else
                    sum = sum + div_floor(64'd1 << (62 - e), 64'(2 * k + 1));
            end
        end
        return sum;
    endfunction

endpackage

/* sv/hpl_mul.sv */
`timescale 1ns / 1ps

module hpl_mul #(
    parameter int MW = hpl_pkg::mul_width(hpl_pkg::FRAC_DEFAULT)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MW-1:0]   a_in,
    input  logic [MW-1:0]   b_in,
    output logic [2*MW-1:0] p_out,
    output logic            done
);
    import hpl_pkg::*;

    localparam int PW = 2 * MW;
    localparam int IW = $clog2(MW);

    logic          busy_reg;
    logic          done_reg;
    logic [IW-1:0] cnt_reg;
    logic [MW-1:0] a_reg;
    logic [MW-1:0] b_reg;
    logic [PW-1:0] acc_reg;
    logic [MW:0]   sum_next;
    logic [PW-1:0] acc_next;

    // One multiplier bit per cycle: add into the upper half, then shift right.
    always_comb
    begin
        sum_next = {1'b0, acc_reg[PW-1:MW]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        acc_next = {sum_next, acc_reg[MW-1:1]};
    end

    // Control of the iteration count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == IW'(MW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg >> 1;
            acc_reg <= acc_next;
        end
    end

    assign p_out = acc_reg;
    assign done  = done_reg;

endmodule

/* sv/hpl_isqrt.sv */
`timescale 1ns / 1ps

module hpl_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [hpl_pkg::SQRT_IN_W-1:0]    v_in,
    output logic [hpl_pkg::SQRT_OUT_W-1:0]   root,
    output logic                             done
);
    import hpl_pkg::*;

    localparam logic [SQRT_IN_W-1:0] TOP_BIT = SQRT_IN_W'(1) << (SQRT_IN_W - 2);

    logic                 busy_reg;
    logic                 done_reg;
    logic [SQRT_IN_W-1:0] v_reg;
    logic [SQRT_IN_W-1:0] res_reg;
    logic [SQRT_IN_W-1:0] bit_reg;
    logic [SQRT_IN_W-1:0] trial;
    logic                 fits;
    logic [SQRT_IN_W-1:0] v_next;
    logic [SQRT_IN_W-1:0] res_next;

    // Restoring square root, one result bit per cycle.
    always_comb
    begin
        trial    = res_reg + bit_reg;
        fits     = (v_reg >= trial);
        v_next   = fits ? (v_reg - trial) : v_reg;
        res_next = fits ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // Control: the last step is the one with the lowest trial bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            v_reg   <= v_in;
            res_reg <= '0;
            bit_reg <= TOP_BIT;
        end
        else if (busy_reg)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[SQRT_OUT_W-1:0];
    assign done = done_reg;

endmodule

/* sv/hpl_cordic.sv */
`timescale 1ns / 1ps

module hpl_cordic #(
    parameter int STEPS = hpl_pkg::STEPS_DEFAULT,
    parameter int FRAC  = hpl_pkg::FRAC_DEFAULT,
    parameter int CW    = hpl_pkg::cordic_width(hpl_pkg::FRAC_DEFAULT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hpl_pkg::cordic_mode_t mode,
    input  logic signed [CW-1:0]  x_in,
    input  logic signed [CW-1:0]  y_in,
    input  logic signed [CW-1:0]  z_in,
    output logic signed [CW-1:0]  x_out,
    output logic signed [CW-1:0]  y_out,
    output logic signed [CW-1:0]  z_out,
    output logic                  done
);
    import hpl_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic signed [CW-1:0] atan_rom [STEPS];
    logic                 busy_reg;
    logic                 done_reg;
    logic [IW-1:0]        cnt_reg;
    cordic_mode_t         mode_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic                 turn_down;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;

    // Angle table atan(2^-i), rounded from Q62 to the angle format.
    for (genvar g = 0; g < STEPS; g++)
    begin : g_atan
        localparam logic [63:0] ATAN_Q62 = atan_q62(g);
        localparam logic [63:0] ATAN_RND =
            (ATAN_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
        assign atan_rom[g] = ATAN_RND[CW-1:0];
    end

    // One micro-rotation. Rotation steers z to zero, vectoring steers y to zero.
    always_comb
    begin
        x_sh      = x_reg >>> cnt_reg;
        y_sh      = y_reg >>> cnt_reg;
        turn_down = (mode_reg == CMODE_ROT) ? !z_reg[CW-1] : y_reg[CW-1];
        if (turn_down)
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_rom[cnt_reg];
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_rom[cnt_reg];
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == IW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Vector and angle registers.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            mode_reg <= mode;
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign done  = done_reg;

endmodule

/* sv/haversine_path_length.sv */
`timescale 1ns / 1ps

// Channel  | Signals                          | Word contents (lowest bit first)
// ---------+----------------------------------+-----------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | lat_in[30:0], lon_in[62:31]; tuser path_start
// output   | m_tvalid m_tready m_tdata m_tuser | segment_cm[30:0], total_cm[78:31]; tuser saturated
//
// One word in, one word out. A point that starts a path skips the arithmetic and
// goes from the preparation step straight to the total. A segment runs nine
// passes of the bit-serial multiplier, of width MW = max(ANGLE_FRAC_BITS+2, 32),
// five CORDIC passes and two square roots. One point is worked on at a time.
// Reset clears the previous point and the total. A stalled output word holds its
// value, and the next input word is taken while it waits.

module haversine_path_length #(
    parameter int CORDIC_STEPS    = hpl_pkg::STEPS_DEFAULT,
    parameter int ANGLE_FRAC_BITS = hpl_pkg::FRAC_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hpl_pkg::S_DATA_W-1:0]  s_tdata,  // lat_in, lon_in, zero fill
    input  logic                          s_tuser,  // path_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hpl_pkg::M_DATA_W-1:0]  m_tdata,  // segment_cm, total_cm, zero fill
    output logic                          m_tuser   // total_saturated
);
    import hpl_pkg::*;

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int CW  = cordic_width(F);
    localparam int MW  = mul_width(F);
    localparam int PW  = 2 * MW;
    localparam int PW1 = PW + 1;
    localparam int UW  = F + 1;
    localparam int ZW  = F + 2;

    localparam logic [UW-1:0]  ONE_Q     = UW'(1) << F;
    localparam logic [PW:0]    HALF_F    = PW1'(1) << (F - 1);
    localparam logic [PW:0]    HALF_FULL = PW1'(1) << (60 - F);
    localparam logic [PW:0]    HALF_HALF = PW1'(1) << (61 - F);
    localparam logic [63:0]    XINIT_W   = (F < 32) ?
        ((64'(INV_GAIN_Q32) + (64'd1 << (31 - F))) >> (32 - F)) :
        (64'(INV_GAIN_Q32) << (F - 32));
    localparam logic signed [CW-1:0] XINIT = XINIT_W[CW-1:0];

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_WRAP,
        S_CONV,
        S_SINCOS,
        S_PROD,
        S_SUMA,
        S_SQRT,
        S_ATAN,
        S_SCALE,
        S_CAP,
        S_TOTAL,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic                      wait_reg;
    logic [1:0]                idx_reg;

    logic signed [LAT_W-1:0]   lat_new_reg;
    logic signed [LON_W-1:0]   lon_new_reg;
    logic                      start_reg;
    logic signed [LAT_W-1:0]   prev_lat_reg;
    logic signed [LON_W-1:0]   prev_lon_reg;
    logic                      have_prev_reg;
    logic [TOTAL_W-1:0]        total_reg;

    logic [MAG_W-1:0]          dlat_mag_reg;
    logic signed [DLON_W-1:0]  dlon_raw_reg;
    logic [MAG_W-1:0]          dlon_mag_reg;
    logic [MAG_W-1:0]          lat1_mag_reg;
    logic [MAG_W-1:0]          lat2_mag_reg;
    logic signed [CW-1:0]      ang_reg [4];
    logic [UW-1:0]             sl_reg;
    logic [UW-1:0]             sn_reg;
    logic [UW-1:0]             c1_reg;
    logic [UW-1:0]             c2_reg;
    logic [UW-1:0]             sl2_reg;
    logic [UW-1:0]             sn2_reg;
    logic [UW-1:0]             c12_reg;
    logic [UW-1:0]             t_reg;
    logic [UW-1:0]             a_reg;
    logic [SQRT_OUT_W-1:0]     ra_reg;
    logic [SQRT_OUT_W-1:0]     rb_reg;
    logic [ZW-1:0]             zpos_reg;
    logic [31:0]               segw_reg;
    logic [SEG_W-1:0]          seg_reg;

    logic                      m_tvalid_reg;
    logic [SEG_W-1:0]          seg_out_reg;
    logic [TOTAL_W-1:0]        total_out_reg;
    logic                      sat_out_reg;

    // Unit connections.
    logic                      mul_start;
    logic [MW-1:0]             mul_a;
    logic [MW-1:0]             mul_b;
    logic [PW-1:0]             mul_p;
    logic                      mul_done;
    logic                      cordic_start;
    cordic_mode_t              cordic_mode;
    logic signed [CW-1:0]      cx_in;
    logic signed [CW-1:0]      cy_in;
    logic signed [CW-1:0]      cz_in;
    logic signed [CW-1:0]      cx_out;
    logic signed [CW-1:0]      cy_out;
    logic signed [CW-1:0]      cz_out;
    logic                      cordic_done;
    logic                      sqrt_start;
    logic [SQRT_IN_W-1:0]      sqrt_v;
    logic [SQRT_OUT_W-1:0]     sqrt_root;
    logic                      sqrt_done;

    // Combinational helpers.
    logic signed [LAT_W-1:0]   lat_in_s;
    logic signed [LAT_W-1:0]   lat_sat;
    logic signed [31:0]        dlat_diff;
    logic signed [DLON_W-1:0]  dlon_diff;
    logic signed [DLON_W-1:0]  dlon_wrap;
    logic [MAG_W-1:0]          dlat_mag;
    logic [MAG_W-1:0]          dlon_mag;
    logic [MAG_W-1:0]          lat1_mag;
    logic [MAG_W-1:0]          lat2_mag;
    logic [PW:0]               rnd_f;
    logic [PW:0]               rnd_full;
    logic [PW:0]               rnd_half;
    logic [UW:0]               a_sum;
    logic [TOTAL_W:0]          total_sum;

    // Clamp a CORDIC output to the range zero to one.
    function automatic logic [UW-1:0] clamp_unit(input logic signed [CW-1:0] v);
        if (v[CW-1])
            return '0;
        else if (v[CW-2:0] > (CW - 1)'(ONE_Q))
            return ONE_Q;
        else
            return v[UW-1:0];
    endfunction

    // Input latitude saturation.
    always_comb
    begin
        lat_in_s = s_tdata[LAT_W-1:0];
        if (lat_in_s > LAT_LIMIT)
            lat_sat = LAT_LIMIT;
        else if (lat_in_s < -LAT_LIMIT)
            lat_sat = -LAT_LIMIT;
        else
            lat_sat = lat_in_s;
    end

    // Coordinate differences and magnitudes.
    always_comb
    begin
        dlat_diff = {lat_new_reg[LAT_W-1], lat_new_reg} - {prev_lat_reg[LAT_W-1], prev_lat_reg};
        dlat_mag  = dlat_diff[31] ? MAG_W'(-dlat_diff) : dlat_diff[MAG_W-1:0];
        dlon_diff = {{(DLON_W - LON_W){lon_new_reg[LON_W-1]}}, lon_new_reg}
                  - {{(DLON_W - LON_W){prev_lon_reg[LON_W-1]}}, prev_lon_reg};
        lat1_mag  = prev_lat_reg[LAT_W-1] ? MAG_W'(-prev_lat_reg) : MAG_W'(prev_lat_reg);
        lat2_mag  = lat_new_reg[LAT_W-1] ? MAG_W'(-lat_new_reg) : MAG_W'(lat_new_reg);
        if (dlon_raw_reg > LON_HALF)
            dlon_wrap = dlon_raw_reg - LON_TURN;
        else if (dlon_raw_reg < -LON_HALF)
            dlon_wrap = dlon_raw_reg + LON_TURN;
        else
            dlon_wrap = dlon_raw_reg;
        dlon_mag  = dlon_wrap[DLON_W-1] ? MAG_W'(-dlon_wrap) : dlon_wrap[MAG_W-1:0];
    end

    // Rounded product scalings, and the sums for a and the total.
    always_comb
    begin
        rnd_f     = ({1'b0, mul_p} + HALF_F) >> F;
        rnd_full  = ({1'b0, mul_p} + HALF_FULL) >> (61 - F);
        rnd_half  = ({1'b0, mul_p} + HALF_HALF) >> (62 - F);
        a_sum     = {1'b0, sl2_reg} + {1'b0, t_reg};
        total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(seg_reg);
    end

    // Multiplier operands.
    always_comb
    begin
        mul_start = !wait_reg &&
                    (state_reg == S_CONV || state_reg == S_PROD || state_reg == S_SCALE);
        mul_a = MW'(EARTH_DIAM_CM);
        mul_b = MW'(zpos_reg);
        case (state_reg)
            S_CONV:
            begin
                mul_b = MW'(DEG7_TO_RAD);
                case (idx_reg)
                    2'd0:    mul_a = MW'(dlat_mag_reg);
                    2'd1:    mul_a = MW'(dlon_mag_reg);
                    2'd2:    mul_a = MW'(lat1_mag_reg);
                    default: mul_a = MW'(lat2_mag_reg);
                endcase
            end
            S_PROD:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        mul_a = MW'(sl_reg);
                        mul_b = MW'(sl_reg);
                    end
                    2'd1:
                    begin
                        mul_a = MW'(sn_reg);
                        mul_b = MW'(sn_reg);
                    end
                    2'd2:
                    begin
                        mul_a = MW'(c1_reg);
                        mul_b = MW'(c2_reg);
                    end
                    default:
                    begin
                        mul_a = MW'(c12_reg);
                        mul_b = MW'(sn2_reg);
                    end
                endcase
            end
            default:
            begin
                mul_a = MW'(EARTH_DIAM_CM);
                mul_b = MW'(zpos_reg);
            end
        endcase
    end

    // CORDIC and square root operands.
    always_comb
    begin
        cordic_start = !wait_reg && (state_reg == S_SINCOS || state_reg == S_ATAN);
        if (state_reg == S_ATAN)
        begin
            cordic_mode = CMODE_VEC;
            cx_in       = CW'(rb_reg);
            cy_in       = CW'(ra_reg);
            cz_in       = '0;
        end
        else
        begin
            cordic_mode = CMODE_ROT;
            cx_in       = XINIT;
            cy_in       = '0;
            cz_in       = ang_reg[idx_reg];
        end
        sqrt_start = !wait_reg && (state_reg == S_SQRT);
        if (idx_reg[0])
            sqrt_v = SQRT_IN_W'(ONE_Q - a_reg) << (62 - F);
        else
            sqrt_v = SQRT_IN_W'(a_reg) << (62 - F);
    end

    hpl_mul #(
        .MW (MW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p_out (mul_p),
        .done  (mul_done)
    );

    hpl_cordic #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (F),
        .CW    (CW)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .mode  (cordic_mode),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .z_in  (cz_in),
        .x_out (cx_out),
        .y_out (cy_out),
        .z_out (cz_out),
        .done  (cordic_done)
    );

    hpl_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .v_in  (sqrt_v),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    // Sequencer: state, path state and the output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            idx_reg       <= '0;
            lat_new_reg   <= '0;
            lon_new_reg   <= '0;
            start_reg     <= 1'b0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            dlat_mag_reg  <= '0;
            dlon_raw_reg  <= '0;
            dlon_mag_reg  <= '0;
            lat1_mag_reg  <= '0;
            lat2_mag_reg  <= '0;
            for (int i = 0; i < 4; i++)
                ang_reg[i] <= '0;
            sl_reg        <= '0;
            sn_reg        <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            sl2_reg       <= '0;
            sn2_reg       <= '0;
            c12_reg       <= '0;
            t_reg         <= '0;
            a_reg         <= '0;
            ra_reg        <= '0;
            rb_reg        <= '0;
            zpos_reg      <= '0;
            segw_reg      <= '0;
            seg_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            seg_out_reg   <= '0;
            total_out_reg <= '0;
            sat_out_reg   <= 1'b0;
        end
        else
        begin
            // The output word leaves on its handshake; a new one is loaded in S_OUT.
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        lat_new_reg <= lat_sat;
                        lon_new_reg <= s_tdata[LAT_W +: LON_W];
                        start_reg   <= s_tuser;
                        state_reg   <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    dlat_mag_reg  <= dlat_mag;
                    dlon_raw_reg  <= dlon_diff;
                    lat1_mag_reg  <= lat1_mag;
                    lat2_mag_reg  <= lat2_mag;
                    prev_lat_reg  <= lat_new_reg;
                    prev_lon_reg  <= lon_new_reg;
                    have_prev_reg <= 1'b1;
                    if (start_reg)
                        total_reg <= '0;
                    if (start_reg || !have_prev_reg)
                    begin
                        seg_reg   <= '0;
                        state_reg <= S_TOTAL;
                    end
                    else
                        state_reg <= S_WRAP;
                end
                S_WRAP:
                begin
                    dlon_mag_reg <= dlon_mag;
                    idx_reg      <= '0;
                    state_reg    <= S_CONV;
                end
                S_CONV:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (mul_done)
                    begin
                        if (idx_reg[1])
                            ang_reg[idx_reg] <= rnd_full[CW-1:0];
                        else
                            ang_reg[idx_reg] <= rnd_half[CW-1:0];
                        wait_reg <= 1'b0;
                        idx_reg  <= idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                            state_reg <= S_SINCOS;
                    end
                end
                S_SINCOS:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (cordic_done)
                    begin
                        case (idx_reg)
                            2'd0:    sl_reg <= clamp_unit(cy_out);
                            2'd1:    sn_reg <= clamp_unit(cy_out);
                            2'd2:    c1_reg <= clamp_unit(cx_out);
                            default: c2_reg <= clamp_unit(cx_out);
                        endcase
                        wait_reg <= 1'b0;
                        idx_reg  <= idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                            state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (mul_done)
                    begin
                        case (idx_reg)
                            2'd0:    sl2_reg <= rnd_f[UW-1:0];
                            2'd1:    sn2_reg <= rnd_f[UW-1:0];
                            2'd2:    c12_reg <= rnd_f[UW-1:0];
                            default: t_reg   <= rnd_f[UW-1:0];
                        endcase
                        wait_reg <= 1'b0;
                        idx_reg  <= idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                            state_reg <= S_SUMA;
                    end
                end
                S_SUMA:
                begin
                    // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), at most one.
                    a_reg     <= (a_sum > {1'b0, ONE_Q}) ? ONE_Q : a_sum[UW-1:0];
                    idx_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (sqrt_done)
                    begin
                        if (idx_reg[0])
                        begin
                            rb_reg    <= sqrt_root;
                            idx_reg   <= '0;
                            state_reg <= S_ATAN;
                        end
                        else
                        begin
                            ra_reg  <= sqrt_root;
                            idx_reg <= 2'd1;
                        end
                        wait_reg <= 1'b0;
                    end
                end
                S_ATAN:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (cordic_done)
                    begin
                        zpos_reg  <= cz_out[CW-1] ? '0 : cz_out[ZW-1:0];
                        wait_reg  <= 1'b0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (mul_done)
                    begin
                        segw_reg  <= rnd_f[31:0];
                        wait_reg  <= 1'b0;
                        state_reg <= S_CAP;
                    end
                end
                S_CAP:
                begin
                    seg_reg   <= (segw_reg > 32'(SEGMENT_MAX)) ? SEGMENT_MAX : segw_reg[SEG_W-1:0];
                    state_reg <= S_TOTAL;
                end
                S_TOTAL:
                begin
                    total_reg <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Wait for the output register to be free.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        seg_out_reg   <= seg_reg;
                        total_out_reg <= total_reg;
                        sat_out_reg   <= (total_reg == TOTAL_MAX);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, total_out_reg, seg_out_reg};
    assign m_tuser  = sat_out_reg;

    // A unit reports completion only while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || cordic_done || sqrt_done) |-> wait_reg)
        else $error("arithmetic unit finished while no operation was pending");

    // The haversine term entering the square roots never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (a_reg <= ONE_Q))
        else $error("haversine term above one");

    // The segment added to the total is already capped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOTAL) |-> (seg_reg <= SEGMENT_MAX))
        else $error("segment length above its cap");

    // An accepted word always starts the preparation step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_PREP))
        else $error("accepted word did not start processing");

endmodule

/* tb/tb_haversine_path_length.sv */
`timescale 1ns / 1ps

module tb_haversine_path_length;

    import hpl_pkg::*;

    // Datapath settings of the instance, mirrored in the predictor.
    localparam int STEPS = 24;
    localparam int FRAC  = 30;

    localparam int RANDOM_POINTS = 380;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int HOLD_AT_WORD  = 60;
    localparam int PHASE1_WORDS  = 140;
    localparam int PHASE2_WORDS  = 280;

    localparam longint LAT_MAX_7 = 64'sd900000000;
    localparam longint LON_FULL  = 64'sd3600000000;
    localparam longint LON_HALF7 = 64'sd1800000000;
    localparam longint unsigned DEG7_RAD_Q62 = 64'd4024455254;
    localparam longint unsigned DIAM_CM      = 64'd1274200000;
    localparam longint unsigned SEG_CAP      = 64'd2001508680;
    localparam longint unsigned TOTAL_CAP    = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic                    start;
    } waypoint_t;

    typedef struct {
        logic [SEG_W-1:0]   seg;
        logic [TOTAL_W-1:0] total;
        logic               sat;
    } leg_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tuser;

    waypoint_t waypoints[$];
    leg_t      expected_legs[$];
    longint    arc_table[STEPS];

    // Predictor state.
    longint          last_lat;
    longint          last_lon;
    bit              last_valid;
    longint unsigned run_total;

    int words_in;
    int words_out;
    int errors;
    int points_total;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    haversine_path_length u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Rounded (a * b) >> s, kept to 64 bits.
    function automatic longint unsigned round_mul(input longint unsigned a,
                                                  input longint unsigned b, input int s);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
        return 64'(p >> s);
    endfunction

    function automatic longint unsigned to_unit(input longint v);
        if (v < 0)
            return 0;
        if (v > (64'sd1 <<< FRAC))
            return 64'd1 << FRAC;
        return v;
    endfunction

    function automatic longint unsigned deg7_to_rad(input longint unsigned n, input int sh);
        return (n * DEG7_RAD_Q62 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Rotation CORDIC; returns sine in sn and cosine in cs, both clamped.
    task automatic rotate(input longint th, output longint unsigned sn,
                          output longint unsigned cs);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = (64'd2608131496 + (64'd1 << (32 - FRAC - 1))) >> (32 - FRAC);
        y = 0;
        z = th;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_table[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_table[i];
            end
        end
        sn = to_unit(y);
        cs = to_unit(x);
    endtask

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_table[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_table[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Great-circle distance in cm between two stored points.
    task automatic leg_length(input longint lat1, input longint lon1, input longint lat2,
                              input longint lon2, output longint unsigned seg);
        longint unsigned one;
        longint unsigned s_lat;
        longint unsigned s_lon;
        longint unsigned c1;
        longint unsigned c2;
        longint unsigned spare;
        longint unsigned hav;
        longint unsigned ra;
        longint unsigned rb;
        longint dlat;
        longint dlon;
        longint z;
        one  = 64'd1 << FRAC;
        dlat = lat2 - lat1;
        dlon = lon2 - lon1;
        if (dlon > LON_HALF7)
            dlon = dlon - LON_FULL;
        if (dlon < -LON_HALF7)
            dlon = dlon + LON_FULL;
        if (dlat < 0)
            dlat = -dlat;
        if (dlon < 0)
            dlon = -dlon;
        if (lat1 < 0)
            lat1 = -lat1;
        if (lat2 < 0)
            lat2 = -lat2;
        rotate(deg7_to_rad(dlat, 62 - FRAC), s_lat, spare);
        rotate(deg7_to_rad(dlon, 62 - FRAC), s_lon, spare);
        rotate(deg7_to_rad(lat1, 61 - FRAC), spare, c1);
        rotate(deg7_to_rad(lat2, 61 - FRAC), spare, c2);
        hav = round_mul(s_lat, s_lat, FRAC)
            + round_mul(round_mul(c1, c2, FRAC), round_mul(s_lon, s_lon, FRAC), FRAC);
        if (hav > one)
            hav = one;
        ra = floor_sqrt(hav << (62 - FRAC));
        rb = floor_sqrt((one - hav) << (62 - FRAC));
        z  = vector_angle(ra, rb);
        if (z < 0)
            z = 0;
        seg = round_mul(DIAM_CM, z, FRAC);
        if (seg > SEG_CAP)
            seg = SEG_CAP;
    endtask

    // Advances the path state by one accepted point and queues its result word.
    task automatic advance_path(input logic signed [LAT_W-1:0] lat_raw,
                                input logic signed [LON_W-1:0] lon_raw, input logic start);
        longint lat;
        longint lon;
        longint unsigned seg;
        leg_t leg;
        lat = lat_raw;
        lon = lon_raw;
        seg = 0;
        if (lat > LAT_MAX_7)
            lat = LAT_MAX_7;
        if (lat < -LAT_MAX_7)
            lat = -LAT_MAX_7;
        if (start)
            run_total = 0;
        if (!start && last_valid)
            leg_length(last_lat, last_lon, lat, lon, seg);
        last_lat   = lat;
        last_lon   = lon;
        last_valid = 1'b1;
        run_total  = run_total + seg;
        if (run_total > TOTAL_CAP)
            run_total = TOTAL_CAP;
        leg.seg   = seg[SEG_W-1:0];
        leg.total = run_total[TOTAL_W-1:0];
        leg.sat   = (run_total == TOTAL_CAP);
        expected_legs.push_back(leg);
    endtask

    task automatic add_point(input longint lat, input longint lon, input logic start);
        waypoint_t w;
        w.lat   = lat[LAT_W-1:0];
        w.lon   = lon[LON_W-1:0];
        w.start = start;
        waypoints.push_back(w);
    endtask

    // Input driver: offers queued points, idling at the current phase's rate.
    always @(posedge clk or negedge rst_n)
    begin
        int idle_pct;
        waypoint_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_path(s_tdata[LAT_W-1:0], s_tdata[LAT_W+LON_W-1:LAT_W], s_tuser);
                words_in = words_in + 1;
            end
            idle_pct = (words_in < PHASE1_WORDS) ? 25 : (words_in < PHASE2_WORDS) ? 66 : 0;
            if (!s_tvalid || s_tready)
            begin
                if (waypoints.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    w = waypoints.pop_front();
                    s_tdata  <= {1'b0, w.lon, w.lat};
                    s_tuser  <= w.start;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each word against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        int idle_pct;
        leg_t leg;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_out = words_out + 1;
                if (expected_legs.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected word, actual %h user %b", $time, m_tdata, m_tuser);
                end
                else
                begin
                    leg = expected_legs.pop_front();
                    if (m_tdata[SEG_W-1:0] !== leg.seg)
                    begin
                        errors = errors + 1;
                        $display("%0t: segment_cm expected %0d actual %0d", $time, leg.seg,
                                 m_tdata[SEG_W-1:0]);
                    end
                    if (m_tdata[SEG_W+TOTAL_W-1:SEG_W] !== leg.total)
                    begin
                        errors = errors + 1;
                        $display("%0t: total_cm expected %0d actual %0d", $time, leg.total,
                                 m_tdata[SEG_W+TOTAL_W-1:SEG_W]);
                    end
                    if (m_tuser !== leg.sat)
                    begin
                        errors = errors + 1;
                        $display("%0t: total_saturated expected %b actual %b", $time, leg.sat,
                                 m_tuser);
                    end
                end
            end
            idle_pct = (words_in < PHASE1_WORDS) ? 66 : (words_in < PHASE2_WORDS) ? 25 : 0;
            // One long hold-off lets the block fill up and stall its input.
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && words_out == HOLD_AT_WORD)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        longint unsigned sum;
        longint unsigned term;
        int e;
        longint lat;
        longint lon;
        int pick;
        logic start;

        rst_n        = 1'b0;
        last_lat     = 0;
        last_lon     = 0;
        last_valid   = 1'b0;
        run_total    = 0;
        words_in     = 0;
        words_out    = 0;
        errors       = 0;
        quiet_cycles = 0;

        // Arctangent table from its power series, rounded to the angle format.
        for (int i = 0; i < STEPS; i++)
        begin
            sum = 64'd3622009729038561421;
            if (i != 0)
            begin
                sum = 0;
                for (int k = 0; k < 32; k++)
                begin
                    e = i * (2 * k + 1);
                    if (e <= 62)
                    begin
                        term = (64'd1 << (62 - e)) / (2 * k + 1);
                        sum  = (k % 2 == 1) ? sum - term : sum + term;
                    end
                end
            end
            arc_table[i] = (sum + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
        end

        // Directed points: no previous point after reset, repeats, antipodes,
        // pole to pole, saturated latitudes, wrapped longitudes, tiny steps.
        add_point(123456789, -98765432, 1'b0);
        add_point(123456789, -98765432, 1'b0);
        add_point(0, 0, 1'b1);
        add_point(0, 1800000000, 1'b0);
        add_point(900000000, 0, 1'b1);
        add_point(-900000000, 0, 1'b0);
        add_point(1073741823, -2147483648, 1'b1);
        add_point(-1073741824, 2147483647, 1'b0);
        add_point(-900000001, 0, 1'b0);
        add_point(0, -1800000000, 1'b1);
        add_point(0, 1800000000, 1'b0);
        add_point(0, -1799999999, 1'b0);
        add_point(500000000, 100, 1'b1);
        add_point(500000001, 101, 1'b0);
        add_point(500000001, 101, 1'b1);
        add_point(-1, -1, 1'b0);
        add_point(899999999, 1799999999, 1'b0);
        add_point(-899999999, -1799999999, 1'b0);

        // Random paths: mostly small steps, some long jumps and raw bit patterns.
        lat = 0;
        lon = 0;
        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            pick  = $urandom_range(99);
            start = ($urandom_range(99) < 8);
            if (pick < 10)
            begin
                lat = $signed(31'($urandom));
                lon = $signed(32'($urandom));
            end
            else if (pick < 30 || start)
            begin
                lat = $signed(32'($urandom_range(1800000000))) - 900000000;
                lon = $signed(32'($urandom_range(2000000000))) * 2 - 2000000000;
            end
            else
            begin
                lat = lat + $signed(32'($urandom_range(4000000))) - 2000000;
                lon = lon + $signed(32'($urandom_range(4000000))) - 2000000;
                if (lat > 1073741823 || lat < -1073741824)
                    lat = 0;
                if (lon > 2147483647 || lon < -2147483648)
                    lon = 0;
            end
            add_point(lat, lon, start);
        end
        points_total = waypoints.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (words_in == points_total && expected_legs.size() == 0);
        repeat (600) @(posedge clk);
        if (errors == 0 && expected_legs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
